/* rtl/core/fpe_pkg.sv */
// ----------------------------------------------------------------------------
// fpe_pkg - shared types for the page frame buffer pixel engine
// Request codes, back-end operation kinds, read-out modes, the command word
// passed from the front end to the back end, and the back-end state type.
// ----------------------------------------------------------------------------
package fpe_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_DISPLAY_WIDTH  = 128;
	localparam int DEF_DISPLAY_HEIGHT = 64;

	// Largest store is 256 columns x 16 pages; address fields are sized for it
	localparam int ADDR_MAX_W = 12;

	// Command queue between front and back end
	localparam int QDEPTH = 2;

	// Request codes on req_type (code 7 is unused and treated as a no-op)
	typedef enum logic [2:0] {
		REQ_WRITE_PIXEL  = 3'd0,
		REQ_TOGGLE_PIXEL = 3'd1,
		REQ_READ_PIXEL   = 3'd2,
		REQ_WRITE_COLUMN = 3'd3,
		REQ_READ_PAGE    = 3'd4,
		REQ_FILL         = 3'd5,
		REQ_INVERT       = 3'd6
	} fpe_req_t;

	// What the back end does with a command
	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,		// read-modify-write of up to two bytes, or a read
		OP_FILL = 2'd1,		// write one value over the whole store
		OP_INV  = 2'd2		// invert the whole store
	} fpe_op_t;

	// What goes out on read_data
	typedef enum logic [1:0] {
		RD_NONE  = 2'd0,
		RD_PIXEL = 2'd1,
		RD_BYTE  = 2'd2
	} fpe_rd_t;

	typedef struct packed {
		fpe_op_t                 op;
		fpe_rd_t                 rd_mode;
		logic [2:0]              bit_sel;
		logic                    toggle;
		logic                    in_range;
		logic [ADDR_MAX_W-1:0]   addr0;
		logic [7:0]              mask0;
		logic [7:0]              data0;
		logic [ADDR_MAX_W-1:0]   addr1;
		logic [7:0]              mask1;
		logic [7:0]              data1;
	} fpe_cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR    = 3'd0,
		ST_IDLE     = 3'd1,
		ST_MOD      = 3'd2,
		ST_MOD2     = 3'd3,
		ST_FILL     = 3'd4,
		ST_INV      = 3'd5,
		ST_INV_LAST = 3'd6
	} fpe_state_t;

endpackage

/* rtl/core/fpe_front.sv */
// ----------------------------------------------------------------------------
// fpe_front - request decode
// Range-checks each request word, works out byte addresses, bit masks and
// data for the back end, and pushes the resulting command into the queue.
// ----------------------------------------------------------------------------
module fpe_front #(
	parameter int DISPLAY_WIDTH  = fpe_pkg::DEF_DISPLAY_WIDTH,
	parameter int DISPLAY_HEIGHT = fpe_pkg::DEF_DISPLAY_HEIGHT
) (
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [2:0]         req_type,
	input  logic signed [8:0]  pos_x,
	input  logic signed [7:0]  pos_y,
	input  logic [2:0]         page_sel,
	input  logic               pixel_value,
	input  logic [7:0]         data_byte,
	input  logic               q_space,
	input  logic               clearing,
	output logic               push,
	output fpe_pkg::fpe_cmd_t  push_cmd
);

	localparam int AW         = fpe_pkg::ADDR_MAX_W;
	localparam int PAGE_COUNT = (DISPLAY_HEIGHT + 7) / 8;
	localparam logic [9:0] WIDTH_L  = 10'(DISPLAY_WIDTH);
	localparam logic [8:0] HEIGHT_L = 9'(DISPLAY_HEIGHT);
	localparam logic [4:0] PAGES_L  = 5'(PAGE_COUNT);

	logic             x_in;
	logic             pix_in;
	logic [8:0]       row_pix;
	logic [3:0]       pix_page;
	logic [7:0]       pix_mask;
	logic [AW-1:0]    pix_addr;
	logic [8:0]       row_col [8];
	logic [7:0]       clip;
	logic [15:0]      mask16;
	logic [15:0]      data16;
	logic [3:0]       page0;
	logic [3:0]       page1;
	logic [AW-1:0]    col_addr0;
	logic [AW-1:0]    col_addr1;
	logic             pg_in;
	logic [AW-1:0]    pg_addr;

	assign req_ready = q_space && !clearing;
	assign push      = req_valid && req_ready;

	// column inside the width
	assign x_in = !pos_x[8] && ({2'b00, pos_x[7:0]} < WIDTH_L);

	// single pixel
	assign row_pix  = {pos_y[7], pos_y};
	assign pix_in   = x_in && !row_pix[8] && (row_pix < HEIGHT_L);
	assign pix_page = pos_y[6:3];
	assign pix_mask = pix_in ? (8'h01 << pos_y[2:0]) : 8'h00;
	assign pix_addr = pix_in ? (AW'(pix_page) * AW'(DISPLAY_WIDTH) + AW'(pos_x[7:0]))
	                         : '0;

	// column byte: clip row by row, then split across two pages
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			row_col[i] = {pos_y[7], pos_y} + 9'(i);
			clip[i]    = x_in && !row_col[i][8] && (row_col[i] < HEIGHT_L);
		end
	end

	assign mask16 = {8'h00, clip} << pos_y[2:0];
	assign data16 = {8'h00, data_byte} << pos_y[2:0];
	// floor(y/8) in two's complement; a page of -1 shows as 15 with its lower
	// byte fully clipped, and the upper byte's page rolls over to 0
	assign page0  = pos_y[6:3];
	assign page1  = pos_y[6:3] + 4'd1;
	assign col_addr0 = (mask16[7:0] != 8'h00)
	                 ? (AW'(page0) * AW'(DISPLAY_WIDTH) + AW'(pos_x[7:0])) : '0;
	assign col_addr1 = (mask16[15:8] != 8'h00)
	                 ? (AW'(page1) * AW'(DISPLAY_WIDTH) + AW'(pos_x[7:0])) : '0;

	// page byte read
	assign pg_in   = x_in && ({2'b00, page_sel} < PAGES_L);
	assign pg_addr = pg_in ? (AW'(page_sel) * AW'(DISPLAY_WIDTH) + AW'(pos_x[7:0])) : '0;

	always_comb begin
		push_cmd          = '0;
		push_cmd.op       = fpe_pkg::OP_BYTE;
		push_cmd.rd_mode  = fpe_pkg::RD_NONE;
		push_cmd.bit_sel  = pos_y[2:0];
		case (req_type)
			fpe_pkg::REQ_WRITE_PIXEL: begin
				push_cmd.in_range = pix_in;
				push_cmd.addr0    = pix_addr;
				push_cmd.mask0    = pix_mask;
				push_cmd.data0    = pixel_value ? pix_mask : 8'h00;
			end
			fpe_pkg::REQ_TOGGLE_PIXEL: begin
				push_cmd.in_range = pix_in;
				push_cmd.addr0    = pix_addr;
				push_cmd.mask0    = pix_mask;
				push_cmd.toggle   = 1'b1;
			end
			fpe_pkg::REQ_READ_PIXEL: begin
				push_cmd.in_range = pix_in;
				push_cmd.addr0    = pix_addr;
				push_cmd.rd_mode  = pix_in ? fpe_pkg::RD_PIXEL : fpe_pkg::RD_NONE;
			end
			fpe_pkg::REQ_WRITE_COLUMN: begin
				push_cmd.in_range = &clip;
				push_cmd.addr0    = col_addr0;
				push_cmd.mask0    = mask16[7:0];
				push_cmd.data0    = data16[7:0];
				push_cmd.addr1    = col_addr1;
				push_cmd.mask1    = mask16[15:8];
				push_cmd.data1    = data16[15:8];
			end
			fpe_pkg::REQ_READ_PAGE: begin
				push_cmd.in_range = pg_in;
				push_cmd.addr0    = pg_addr;
				push_cmd.rd_mode  = pg_in ? fpe_pkg::RD_BYTE : fpe_pkg::RD_NONE;
			end
			fpe_pkg::REQ_FILL: begin
				push_cmd.op       = fpe_pkg::OP_FILL;
				push_cmd.in_range = 1'b1;
				push_cmd.data0    = data_byte;
			end
			fpe_pkg::REQ_INVERT: begin
				push_cmd.op       = fpe_pkg::OP_INV;
				push_cmd.in_range = 1'b1;
			end
			default: begin
				// unused code: no write, zero result, out of range
				push_cmd.in_range = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/core/fpe_cmdq.sv */
// ----------------------------------------------------------------------------
// fpe_cmdq - command queue
// Small FIFO of decoded commands between the front end and the back end.
// ----------------------------------------------------------------------------
module fpe_cmdq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  fpe_pkg::fpe_cmd_t  push_cmd,
	output logic               space,
	input  logic               pop,
	output logic               head_valid,
	output fpe_pkg::fpe_cmd_t  head
);

	localparam int DEPTH = fpe_pkg::QDEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	fpe_pkg::fpe_cmd_t  entry_q [DEPTH];
	logic [PW-1:0]      wptr_q;
	logic [PW-1:0]      rptr_q;
	logic [CW-1:0]      count_q;

	assign space      = (count_q != CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wptr_q] <= push_cmd;
	end

endmodule

/* rtl/core/fpe_back.sv */
// ----------------------------------------------------------------------------
// fpe_back - frame store and execution
// Holds the frame memory, runs the clearing pass after reset, executes
// read-modify-write, fill and invert commands and drives the result register.
// ----------------------------------------------------------------------------
module fpe_back #(
	parameter int DISPLAY_WIDTH  = fpe_pkg::DEF_DISPLAY_WIDTH,
	parameter int DISPLAY_HEIGHT = fpe_pkg::DEF_DISPLAY_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  fpe_pkg::fpe_cmd_t  head,
	output logic               pop,
	output logic               clearing,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [7:0]         read_data,
	output logic               in_range
);

	localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
	localparam int STORE_BYTES = PAGE_COUNT * DISPLAY_WIDTH;
	localparam int AW          = $clog2(STORE_BYTES);

	fpe_pkg::fpe_state_t  state_q;
	fpe_pkg::fpe_state_t  state_d;

	logic [7:0]         mem [STORE_BYTES];
	logic [7:0]         rdata_q;
	fpe_pkg::fpe_cmd_t  cmd_q;
	logic [AW-1:0]      sweep_q;
	logic [AW-1:0]      inv_wa_q;
	logic               inv_pend_q;
	logic               rsp_valid_q;
	logic [7:0]         read_data_q;
	logic               in_range_q;

	logic               start;
	logic               sweep_last;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic [7:0]         mem_wd;
	logic [AW-1:0]      rd_addr;
	logic               out_load;
	logic [7:0]         out_data;
	logic               out_range;

	assign start      = head_valid && (!rsp_valid_q || rsp_ready);
	assign sweep_last = (sweep_q == AW'(STORE_BYTES - 1));
	assign clearing   = (state_q == fpe_pkg::ST_CLEAR);

	assign rsp_valid = rsp_valid_q;
	assign read_data = read_data_q;
	assign in_range  = in_range_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fpe_pkg::ST_CLEAR: begin
				if (sweep_last)
					state_d = fpe_pkg::ST_IDLE;
			end
			fpe_pkg::ST_IDLE: begin
				if (start) begin
					case (head.op)
						fpe_pkg::OP_FILL: state_d = fpe_pkg::ST_FILL;
						fpe_pkg::OP_INV:  state_d = fpe_pkg::ST_INV;
						default:          state_d = fpe_pkg::ST_MOD;
					endcase
				end
			end
			fpe_pkg::ST_MOD: begin
				state_d = (cmd_q.mask1 != 8'h00) ? fpe_pkg::ST_MOD2 : fpe_pkg::ST_IDLE;
			end
			fpe_pkg::ST_MOD2: state_d = fpe_pkg::ST_IDLE;
			fpe_pkg::ST_FILL: begin
				if (sweep_last)
					state_d = fpe_pkg::ST_IDLE;
			end
			fpe_pkg::ST_INV: begin
				if (sweep_last)
					state_d = fpe_pkg::ST_INV_LAST;
			end
			fpe_pkg::ST_INV_LAST: state_d = fpe_pkg::ST_IDLE;
			default: state_d = fpe_pkg::ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		pop       = 1'b0;
		mem_we    = 1'b0;
		mem_wa    = '0;
		mem_wd    = 8'h00;
		rd_addr   = '0;
		out_load  = 1'b0;
		out_data  = 8'h00;
		out_range = cmd_q.in_range;
		case (state_q)
			fpe_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = sweep_q;
			end
			fpe_pkg::ST_IDLE: begin
				pop     = start;
				rd_addr = head.addr0[AW-1:0];
			end
			fpe_pkg::ST_MOD: begin
				mem_we  = (cmd_q.mask0 != 8'h00);
				mem_wa  = cmd_q.addr0[AW-1:0];
				mem_wd  = cmd_q.toggle ? (rdata_q ^ cmd_q.mask0)
				        : ((rdata_q & ~cmd_q.mask0) | (cmd_q.data0 & cmd_q.mask0));
				rd_addr = cmd_q.addr1[AW-1:0];
				out_load = (cmd_q.mask1 == 8'h00);
				case (cmd_q.rd_mode)
					fpe_pkg::RD_PIXEL: out_data = {7'd0, rdata_q[cmd_q.bit_sel]};
					fpe_pkg::RD_BYTE:  out_data = rdata_q;
					default:           out_data = 8'h00;
				endcase
			end
			fpe_pkg::ST_MOD2: begin
				// second page of a column byte; reads never get here
				mem_we   = 1'b1;
				mem_wa   = cmd_q.addr1[AW-1:0];
				mem_wd   = (rdata_q & ~cmd_q.mask1) | (cmd_q.data1 & cmd_q.mask1);
				out_load = 1'b1;
			end
			fpe_pkg::ST_FILL: begin
				mem_we   = 1'b1;
				mem_wa   = sweep_q;
				mem_wd   = cmd_q.data0;
				out_load = sweep_last;
			end
			fpe_pkg::ST_INV: begin
				// read byte i while writing back byte i-1
				rd_addr = sweep_q;
				mem_we  = inv_pend_q;
				mem_wa  = inv_wa_q;
				mem_wd  = ~rdata_q;
			end
			fpe_pkg::ST_INV_LAST: begin
				mem_we   = 1'b1;
				mem_wa   = inv_wa_q;
				mem_wd   = ~rdata_q;
				out_load = 1'b1;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpe_pkg::ST_CLEAR;
			sweep_q     <= '0;
			inv_pend_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fpe_pkg::ST_CLEAR || state_q == fpe_pkg::ST_FILL ||
			    state_q == fpe_pkg::ST_INV)
				sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
			inv_pend_q <= (state_q == fpe_pkg::ST_INV);
			if (out_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= head;
		inv_wa_q <= sweep_q;
		if (out_load) begin
			read_data_q <= out_data;
			in_range_q  <= out_range;
		end
	end

	// frame memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rdata_q <= mem[rd_addr];
	end

endmodule

/* rtl/core/page_framebuffer_pixel_engine.sv */
// ----------------------------------------------------------------------------
// page_framebuffer_pixel_engine - monochrome page frame store with pixel ops
// Frame store of DISPLAY_WIDTH columns by DISPLAY_HEIGHT rows held as pages
// of eight rows, bit y%8 of byte [y/8][x] being pixel (x,y). Supports pixel
// write, toggle and read, clipped column byte writes, page byte reads, and
// whole-store fill and invert.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | word
//  --------+-----------------------+---------------------------------------------
//  request | req_valid / req_ready | req_type pos_x pos_y page_sel pixel_value
//          |                       | data_byte
//  result  | rsp_valid / rsp_ready | read_data in_range
//
//  Steps: a pixel op, a page byte read or a one-page column byte is a pop
//  with the read issued, then read-modify-write on the frame memory; a two-page
//  column byte adds a write of its second page. Fill and invert go one byte a cycle.
//  Reset: a clearing pass over all STORE_BYTES bytes (1024 at 128x64) zeroes the
//  store with req_ready low. Stalls: a two-word queue keeps the front taking
//  words while the back end works or waits on a full result register.
//
module page_framebuffer_pixel_engine #(
	parameter int DISPLAY_WIDTH  = fpe_pkg::DEF_DISPLAY_WIDTH,
	parameter int DISPLAY_HEIGHT = fpe_pkg::DEF_DISPLAY_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [2:0]         req_type,
	input  logic signed [8:0]  pos_x,
	input  logic signed [7:0]  pos_y,
	input  logic [2:0]         page_sel,
	input  logic               pixel_value,
	input  logic [7:0]         data_byte,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [7:0]         read_data,
	output logic               in_range
);

	logic               push;
	fpe_pkg::fpe_cmd_t  push_cmd;
	logic               q_space;
	logic               pop;
	logic               head_valid;
	fpe_pkg::fpe_cmd_t  head;
	logic               clearing;

	// decode and range check
	fpe_front #(
		.DISPLAY_WIDTH  (DISPLAY_WIDTH),
		.DISPLAY_HEIGHT (DISPLAY_HEIGHT)
	) u_front (
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req_type    (req_type),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.page_sel    (page_sel),
		.pixel_value (pixel_value),
		.data_byte   (data_byte),
		.q_space     (q_space),
		.clearing    (clearing),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	// decoupling queue
	fpe_cmdq u_cmdq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.space      (q_space),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// frame memory and execution
	fpe_back #(
		.DISPLAY_WIDTH  (DISPLAY_WIDTH),
		.DISPLAY_HEIGHT (DISPLAY_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.clearing   (clearing),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.read_data  (read_data),
		.in_range   (in_range)
	);

endmodule
